@@ rtl/fwesd_pkg.sv @@
package fwesd_pkg;

	localparam int WHEEL_COUNT = 4;
	localparam int DUTY_W      = 8;
	localparam int GAIN_W      = 16;
	localparam int FRAC_BITS   = 8;
	localparam int TARGET_W    = 16;
	localparam int CFG_DATA_W  = 16;
	localparam int CFG_INDEX_W = 1;

	localparam logic [DUTY_W-1:0] DUTY_MAX          = 8'd255;
	localparam logic [DUTY_W-1:0] BASE_DUTY_RESET   = 8'd128;
	localparam logic [GAIN_W-1:0] CORR_GAIN_RESET   = 16'd256;

	typedef enum logic {
		OP_START = 1'b0,
		OP_STEP  = 1'b1
	} op_t;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_BASE_DUTY       = 1'b0,
		REG_CORRECTION_GAIN = 1'b1
	} reg_index_t;

	typedef struct packed {
		logic [DUTY_W-1:0] base_duty;
		logic [GAIN_W-1:0] correction_gain;
	} cfg_t;

endpackage

@@ rtl/fwesd_cfg_regs.sv @@
module fwesd_cfg_regs (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [fwesd_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  logic [fwesd_pkg::CFG_DATA_W-1:0]   cfg_data,
	output fwesd_pkg::cfg_t                    cfg
);

	fwesd_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.base_duty       <= fwesd_pkg::BASE_DUTY_RESET;
			cfg_q.correction_gain <= fwesd_pkg::CORR_GAIN_RESET;
		end else if (cfg_we) begin
			case (fwesd_pkg::reg_index_t'(cfg_index))
				fwesd_pkg::REG_BASE_DUTY: begin
					cfg_q.base_duty <= cfg_data[fwesd_pkg::DUTY_W-1:0];
				end
				fwesd_pkg::REG_CORRECTION_GAIN: begin
					cfg_q.correction_gain <= cfg_data[fwesd_pkg::GAIN_W-1:0];
				end
				default: begin
					cfg_q <= cfg_q;
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

@@ rtl/fwesd_wheel_duty.sv @@
module fwesd_wheel_duty #(
	parameter int COUNT_WIDTH = 16
) (
	input  fwesd_pkg::cfg_t                     cfg,
	input  logic [COUNT_WIDTH-1:0]              avg,
	input  logic [COUNT_WIDTH-1:0]              own,
	input  logic [fwesd_pkg::TARGET_W-1:0]      goal,
	output logic [fwesd_pkg::DUTY_W-1:0]        duty
);

	localparam int PROD_W = COUNT_WIDTH + fwesd_pkg::GAIN_W;
	localparam int CORR_W = PROD_W - fwesd_pkg::FRAC_BITS;
	localparam int GOAL_CMP_W = (COUNT_WIDTH > fwesd_pkg::TARGET_W) ?
		COUNT_WIDTH : fwesd_pkg::TARGET_W;

	logic                   ahead;
	logic [COUNT_WIDTH-1:0] mag;
	logic [PROD_W-1:0]      prod;
	logic [CORR_W-1:0]      corr;
	logic [CORR_W:0]        up;
	logic                   stopped;

	assign ahead   = (avg >= own);
	assign mag     = ahead ? (avg - own) : (own - avg);
	assign prod    = PROD_W'(mag) * PROD_W'(cfg.correction_gain);
	assign corr    = prod[PROD_W-1:fwesd_pkg::FRAC_BITS];
	assign up      = (CORR_W+1)'(cfg.base_duty) + (CORR_W+1)'(corr);
	assign stopped = (GOAL_CMP_W'(own) >= GOAL_CMP_W'(goal));

	always_comb begin
		if (stopped) begin
			duty = '0;
		end else if (ahead) begin
			if (up > (CORR_W+1)'(fwesd_pkg::DUTY_MAX)) begin
				duty = fwesd_pkg::DUTY_MAX;
			end else begin
				duty = up[fwesd_pkg::DUTY_W-1:0];
			end
		end else begin
			if (corr > CORR_W'(cfg.base_duty)) begin
				duty = '0;
			end else begin
				duty = cfg.base_duty - corr[fwesd_pkg::DUTY_W-1:0];
			end
		end
	end

endmodule

@@ rtl/four_wheel_encoder_sync_drive.sv @@
// Channel  | Handshake             | Payload
// command  | cmd_valid, cmd_stall  | op, target_ticks, pulse_front_left .. pulse_rear_right
// result   | res_valid, res_stall  | duty_front_left .. duty_rear_right, moving, done_res
// config   | cfg_we                | cfg_index, cfg_data
//
// Each item is taken into the input register and then moves to the result register,
// which presents its result. One item is accepted every cycle unless a stalled
// result holds the result register; the counter update, the sum compare and the
// per-wheel correction multiply all sit between the input and result registers.
// Reset clears the wheel counters, the goal and the move flag at once.
// A stalled result holds the result register, and the command side stalls only
// when the input register is full behind it.
module four_wheel_encoder_sync_drive #(
	parameter int COUNT_WIDTH = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cmd_valid,
	output logic                               cmd_stall,
	input  logic                               op,
	input  logic [fwesd_pkg::TARGET_W-1:0]     target_ticks,
	input  logic                               pulse_front_left,
	input  logic                               pulse_front_right,
	input  logic                               pulse_rear_left,
	input  logic                               pulse_rear_right,
	output logic                               res_valid,
	input  logic                               res_stall,
	output logic [fwesd_pkg::DUTY_W-1:0]       duty_front_left,
	output logic [fwesd_pkg::DUTY_W-1:0]       duty_front_right,
	output logic [fwesd_pkg::DUTY_W-1:0]       duty_rear_left,
	output logic [fwesd_pkg::DUTY_W-1:0]       duty_rear_right,
	output logic                               moving,
	output logic                               done_res,
	input  logic                               cfg_we,
	input  logic [fwesd_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  logic [fwesd_pkg::CFG_DATA_W-1:0]   cfg_data
);

	localparam int NW     = fwesd_pkg::WHEEL_COUNT;
	localparam int SUM_W  = COUNT_WIDTH + 2;
	localparam int GOAL4_W = fwesd_pkg::TARGET_W + 2;
	localparam int CMP_W  = (SUM_W > GOAL4_W) ? SUM_W : GOAL4_W;

	fwesd_pkg::cfg_t cfg;

	logic                              valid_s1;
	fwesd_pkg::op_t                    op_s1;
	logic [fwesd_pkg::TARGET_W-1:0]    target_s1;
	logic [NW-1:0]                     pulse_s1;

	logic [COUNT_WIDTH-1:0]            cnt_q [NW];
	logic [SUM_W-1:0]                  sum_q;
	logic [fwesd_pkg::TARGET_W-1:0]    goal_q;
	logic                              active_q;

	logic                              res_valid_q;
	logic [fwesd_pkg::DUTY_W-1:0]      duty_q [NW];
	logic                              moving_q;
	logic                              done_q;

	logic                              out_free;
	logic                              fire;
	logic                              is_step;
	logic [NW-1:0]                     inc;
	logic [2:0]                        inc_total;
	logic [COUNT_WIDTH-1:0]            cnt_new [NW];
	logic [SUM_W-1:0]                  sum_new;
	logic                              finish;
	logic [COUNT_WIDTH-1:0]            avg;
	logic [fwesd_pkg::DUTY_W-1:0]      wheel_duty [NW];

	fwesd_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	assign out_free  = !res_valid_q || !res_stall;
	assign fire      = valid_s1 && out_free;
	assign cmd_stall = valid_s1 && !out_free;
	assign is_step   = (op_s1 == fwesd_pkg::OP_STEP);

	always_comb begin
		for (int i = 0; i < NW; i++) begin
			inc[i] = is_step && active_q && pulse_s1[i] &&
				(cnt_q[i] != {COUNT_WIDTH{1'b1}});
			cnt_new[i] = cnt_q[i] + COUNT_WIDTH'(inc[i]);
		end
	end

	assign inc_total = 3'(inc[0]) + 3'(inc[1]) + 3'(inc[2]) + 3'(inc[3]);
	assign sum_new   = sum_q + SUM_W'(inc_total);
	assign finish    = (CMP_W'(sum_new) >= CMP_W'({goal_q, 2'b00}));
	assign avg       = sum_new[SUM_W-1:2];

	for (genvar w = 0; w < NW; w++) begin : g_wheel
		fwesd_wheel_duty #(
			.COUNT_WIDTH (COUNT_WIDTH)
		) u_duty (
			.cfg  (cfg),
			.avg  (avg),
			.own  (cnt_new[w]),
			.goal (goal_q),
			.duty (wheel_duty[w])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!cmd_stall) begin
			valid_s1 <= cmd_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_valid && !cmd_stall) begin
			op_s1     <= fwesd_pkg::op_t'(op);
			target_s1 <= target_ticks;
			pulse_s1  <= {pulse_rear_right, pulse_rear_left, pulse_front_right,
				pulse_front_left};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NW; i++) begin
				cnt_q[i] <= '0;
			end
			sum_q    <= '0;
			goal_q   <= '0;
			active_q <= 1'b0;
		end else if (fire) begin
			if (!is_step) begin
				for (int i = 0; i < NW; i++) begin
					cnt_q[i] <= '0;
				end
				sum_q    <= '0;
				goal_q   <= target_s1;
				active_q <= (target_s1 != '0);
			end else if (active_q) begin
				for (int i = 0; i < NW; i++) begin
					cnt_q[i] <= cnt_new[i];
				end
				sum_q <= sum_new;
				if (finish) begin
					active_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (out_free) begin
			res_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			for (int i = 0; i < NW; i++) begin
				duty_q[i] <= '0;
			end
			moving_q <= 1'b0;
			done_q   <= 1'b0;
			if (!is_step) begin
				if (target_s1 == '0) begin
					done_q <= 1'b1;
				end else begin
					for (int i = 0; i < NW; i++) begin
						duty_q[i] <= cfg.base_duty;
					end
					moving_q <= 1'b1;
				end
			end else if (active_q) begin
				if (finish) begin
					done_q <= 1'b1;
				end else begin
					for (int i = 0; i < NW; i++) begin
						duty_q[i] <= wheel_duty[i];
					end
					moving_q <= 1'b1;
				end
			end
		end
	end

	assign res_valid        = res_valid_q;
	assign duty_front_left  = duty_q[0];
	assign duty_front_right = duty_q[1];
	assign duty_rear_left   = duty_q[2];
	assign duty_rear_right  = duty_q[3];
	assign moving           = moving_q;
	assign done_res         = done_q;

endmodule

@@ rtl/fwesd_checker.sv @@
module fwesd_checker (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               cmd_stall,
	input logic                               res_valid,
	input logic                               res_stall,
	input logic [fwesd_pkg::DUTY_W-1:0]       duty_front_left,
	input logic [fwesd_pkg::DUTY_W-1:0]       duty_front_right,
	input logic [fwesd_pkg::DUTY_W-1:0]       duty_rear_left,
	input logic [fwesd_pkg::DUTY_W-1:0]       duty_rear_right,
	input logic                               moving,
	input logic                               done_res
);

	// A held result keeps its payload until it is taken.
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(duty_front_left) &&
		$stable(duty_front_right) && $stable(duty_rear_left) &&
		$stable(duty_rear_right) && $stable(moving) && $stable(done_res))
	else $error("held result changed");

	// The item that ends a move never reports the move as still running.
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && done_res |-> !moving)
	else $error("done and moving together");

	// Whenever no move is running, every wheel is off.
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !moving |-> duty_front_left == '0 && duty_front_right == '0 &&
		duty_rear_left == '0 && duty_rear_right == '0)
	else $error("wheel driven while idle");

	// The command side only stalls when a result is waiting behind a stall.
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd_stall |-> res_valid && res_stall)
	else $error("command stalled without result backpressure");

endmodule

bind four_wheel_encoder_sync_drive fwesd_checker u_fwesd_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.cmd_stall        (cmd_stall),
	.res_valid        (res_valid),
	.res_stall        (res_stall),
	.duty_front_left  (duty_front_left),
	.duty_front_right (duty_front_right),
	.duty_rear_left   (duty_rear_left),
	.duty_rear_right  (duty_rear_right),
	.moving           (moving),
	.done_res         (done_res)
);
